### rtl/core/lcdnw_pkg.sv
// Shared types, opcodes and cursor helpers for the 4-bit character display writer.
// No dependencies; used by the interfaces, the top level and the bench.
package lcdnw_pkg;

	typedef enum logic [2:0] {
		OP_CMD       = 3'd0,
		OP_CHAR      = 3'd1,
		OP_SET_CUR   = 3'd2,
		OP_CLEAR     = 3'd3,
		OP_SHIFT_R   = 3'd4,
		OP_SHIFT_L   = 3'd5,
		OP_DELETE    = 3'd6,
		OP_INIT      = 3'd7
	} op_t;

	localparam int MAX_BYTES = 6;
	localparam int BIDX_W    = $clog2(MAX_BYTES);
	localparam int NCNT_W    = $clog2(2 * MAX_BYTES + 1);

	localparam logic [4:0] LAST_POS  = 5'd31;
	localparam logic [4:0] ROW_END   = 5'd15;
	localparam logic [4:0] ROW1_HOME = 5'd16;

	localparam logic [7:0] CMD_INIT0   = 8'h33;
	localparam logic [7:0] CMD_INIT1   = 8'h32;
	localparam logic [7:0] CMD_FUNC    = 8'h28;
	localparam logic [7:0] CMD_DISP    = 8'h0F;
	localparam logic [7:0] CMD_ENTRY   = 8'h06;
	localparam logic [7:0] CMD_CLEAR   = 8'h01;
	localparam logic [7:0] CMD_SHIFT_R = 8'h14;
	localparam logic [7:0] CMD_SHIFT_L = 8'h10;
	localparam logic [7:0] CMD_DDRAM   = 8'h80;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_LO     = 8'd32;
	localparam logic [7:0] CHAR_HI     = 8'd125;

	typedef struct packed {
		logic       emit;
		logic [7:0] cmd;
		logic [4:0] pos;
	} mv_t;

	// One step right; row end and wrap re-address the display.
	function automatic mv_t move_right(input logic [4:0] p);
		mv_t m;
		m.emit = 1'b0;
		m.cmd  = CMD_DDRAM;
		m.pos  = p + 5'd1;
		if (p == ROW_END) begin
			m.emit = 1'b1;
			m.cmd  = 8'hC0;
			m.pos  = ROW1_HOME;
		end else if (p == LAST_POS) begin
			m.emit = 1'b1;
			m.cmd  = 8'h80;
			m.pos  = 5'd0;
		end
		return m;
	endfunction

	function automatic mv_t move_left(input logic [4:0] p);
		mv_t m;
		m.emit = 1'b0;
		m.cmd  = CMD_DDRAM;
		m.pos  = p - 5'd1;
		if (p == ROW1_HOME) begin
			m.emit = 1'b1;
			m.cmd  = 8'h8F;
			m.pos  = ROW_END;
		end else if (p == 5'd0) begin
			m.emit = 1'b1;
			m.cmd  = 8'hCF;
			m.pos  = LAST_POS;
		end
		return m;
	endfunction

endpackage

### rtl/core/lcdnw_op_if.sv
// Operation channel: valid/ready with one display operation per beat.
// Depends on lcdnw_pkg.
interface lcdnw_op_if import lcdnw_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [7:0] byte_value;
	logic [7:0] row;
	logic [7:0] column;

	modport source (output valid, operation, byte_value, row, column, input ready);
	modport sink   (input valid, operation, byte_value, row, column, output ready);
endinterface

### rtl/core/lcdnw_nib_if.sv
// Nibble write channel: valid/ready with one register-select tagged nibble per beat.
// Depends on lcdnw_pkg.
interface lcdnw_nib_if import lcdnw_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       register_select;
	logic [3:0] nibble;
	logic       last;
	logic [4:0] cursor;

	modport source (output valid, register_select, nibble, last, cursor, input ready);
	modport sink   (input valid, register_select, nibble, last, cursor, output ready);
endinterface

### rtl/core/char_lcd_nibble_writer_with_cursor.sv
// Top level: turns display operations into high-first nibble writes and tracks the cursor.
// Depends on lcdnw_pkg, lcdnw_op_if, lcdnw_nib_if.
//
//  port  dir   beat
//  req   sink  operation, byte_value, row, column
//  nib   src   register_select, nibble, last, cursor
//
// An operation is decoded into up to six bytes in the cycle it is taken; the byte
// list then drains one nibble per cycle while nib is ready, and an operation that
// sends no byte leaves no job. The next item is taken in the cycle the last nibble
// moves to the output register, which loads only when empty or taken, so a nib stall
// also holds the job register. Reset clears the cursor and all valid flags.
module char_lcd_nibble_writer_with_cursor import lcdnw_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	lcdnw_op_if.sink     req,
	lcdnw_nib_if.source  nib
);

	logic [4:0] cursor_q;

	// decoded operation
	logic [7:0]        byte_c [MAX_BYTES];
	logic              rs_c   [MAX_BYTES];
	logic [BIDX_W:0]   cnt_c;
	logic [4:0]        cur_c;

	// job register
	logic              job_valid_q;
	logic [7:0]        byte_s1 [MAX_BYTES];
	logic              rs_s1   [MAX_BYTES];
	logic [NCNT_W-1:0] nib_cnt_s1;
	logic [NCNT_W-1:0] nib_idx_s1;
	logic [4:0]        cur_s1;

	// output register
	logic       out_valid_q;
	logic       out_rs_q;
	logic [3:0] out_nib_q;
	logic       out_last_q;
	logic [4:0] out_cur_q;

	logic accept, out_load, job_adv, job_last, job_done;
	logic [BIDX_W-1:0] sel;
	logic [7:0]        sel_byte;

	always_comb begin : decode
		mv_t m;
		m      = '0;
		cur_c  = cursor_q;
		cnt_c  = '0;
		for (int i = 0; i < MAX_BYTES; i++) begin
			byte_c[i] = '0;
			rs_c[i]   = 1'b0;
		end
		case (op_t'(req.operation))
			OP_CMD: begin
				byte_c[0] = req.byte_value;
				cnt_c     = (BIDX_W+1)'(1);
			end
			OP_CHAR: begin
				if (req.byte_value >= CHAR_LO && req.byte_value <= CHAR_HI) begin
					byte_c[0] = req.byte_value;
					rs_c[0]   = 1'b1;
					cnt_c     = (BIDX_W+1)'(1);
					m         = move_right(cursor_q);
					cur_c     = m.pos;
					if (m.emit) begin
						byte_c[1] = m.cmd;
						cnt_c     = (BIDX_W+1)'(2);
					end
				end
			end
			OP_SET_CUR: begin
				byte_c[0] = ({req.row[1:0], 6'd0} + req.column) | CMD_DDRAM;
				cnt_c     = (BIDX_W+1)'(1);
				if (req.column <= 8'd15) begin
					if (req.row == 8'd0)
						cur_c = {1'b0, req.column[3:0]};
					else if (req.row == 8'd1)
						cur_c = {1'b1, req.column[3:0]};
				end
			end
			OP_CLEAR: begin
				byte_c[0] = CMD_CLEAR;
				cnt_c     = (BIDX_W+1)'(1);
				cur_c     = '0;
			end
			OP_SHIFT_R: begin
				if (cursor_q < LAST_POS) begin
					byte_c[0] = CMD_SHIFT_R;
					cnt_c     = (BIDX_W+1)'(1);
					m         = move_right(cursor_q);
					cur_c     = m.pos;
					if (m.emit) begin
						byte_c[1] = m.cmd;
						cnt_c     = (BIDX_W+1)'(2);
					end
				end
			end
			OP_SHIFT_L: begin
				byte_c[0] = CMD_SHIFT_L;
				cnt_c     = (BIDX_W+1)'(1);
				m         = move_left(cursor_q);
				cur_c     = m.pos;
				if (m.emit) begin
					byte_c[1] = m.cmd;
					cnt_c     = (BIDX_W+1)'(2);
				end
			end
			OP_DELETE: begin
				// left, space, left; each move may add a re-address
				byte_c[0] = CMD_SHIFT_L;
				cnt_c     = (BIDX_W+1)'(1);
				m         = move_left(cur_c);
				cur_c     = m.pos;
				if (m.emit) begin
					byte_c[cnt_c[BIDX_W-1:0]] = m.cmd;
					cnt_c = cnt_c + 1'b1;
				end
				byte_c[cnt_c[BIDX_W-1:0]] = CHAR_SPACE;
				rs_c[cnt_c[BIDX_W-1:0]]   = 1'b1;
				cnt_c = cnt_c + 1'b1;
				m     = move_right(cur_c);
				cur_c = m.pos;
				if (m.emit) begin
					byte_c[cnt_c[BIDX_W-1:0]] = m.cmd;
					cnt_c = cnt_c + 1'b1;
				end
				byte_c[cnt_c[BIDX_W-1:0]] = CMD_SHIFT_L;
				cnt_c = cnt_c + 1'b1;
				m     = move_left(cur_c);
				cur_c = m.pos;
				if (m.emit) begin
					byte_c[cnt_c[BIDX_W-1:0]] = m.cmd;
					cnt_c = cnt_c + 1'b1;
				end
			end
			OP_INIT: begin
				byte_c[0] = CMD_INIT0;
				byte_c[1] = CMD_INIT1;
				byte_c[2] = CMD_FUNC;
				byte_c[3] = CMD_DISP;
				byte_c[4] = CMD_ENTRY;
				byte_c[5] = CMD_CLEAR;
				cnt_c     = (BIDX_W+1)'(MAX_BYTES);
				cur_c     = '0;
			end
			default: begin
				cnt_c = '0;
			end
		endcase
	end

	assign out_load  = !out_valid_q || nib.ready;
	assign job_adv   = job_valid_q && out_load;
	assign job_last  = (nib_idx_s1 == nib_cnt_s1 - 1'b1);
	assign job_done  = job_adv && job_last;
	assign req.ready = !job_valid_q || job_done;
	assign accept    = req.valid && req.ready;

	assign sel      = nib_idx_s1[BIDX_W:1];
	assign sel_byte = byte_s1[sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			job_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cursor_q    <= cur_c;
				job_valid_q <= (cnt_c != '0);
			end else if (job_done) begin
				job_valid_q <= 1'b0;
			end
			if (out_load)
				out_valid_q <= job_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_BYTES; i++) begin
				byte_s1[i] <= byte_c[i];
				rs_s1[i]   <= rs_c[i];
			end
			nib_cnt_s1 <= NCNT_W'({cnt_c, 1'b0});
			nib_idx_s1 <= '0;
			cur_s1     <= cur_c;
		end else if (job_adv) begin
			nib_idx_s1 <= nib_idx_s1 + 1'b1;
		end
		if (job_adv) begin
			out_rs_q   <= rs_s1[sel];
			out_nib_q  <= nib_idx_s1[0] ? sel_byte[3:0] : sel_byte[7:4];
			out_last_q <= job_last;
			out_cur_q  <= cur_s1;
		end
	end

	assign nib.valid           = out_valid_q;
	assign nib.register_select = out_rs_q;
	assign nib.nibble          = out_nib_q;
	assign nib.last            = out_last_q;
	assign nib.cursor          = out_cur_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> (nib_idx_s1 < nib_cnt_s1))
		else $error("nibble index past end of job");

	a_job_even: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> (nib_cnt_s1[0] == 1'b0 && nib_cnt_s1 != '0))
		else $error("job nibble count not a whole number of bytes");

	a_mid_job: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> job_valid_q)
		else $error("non-final nibble shown with no job pending");

	a_job_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid_q && !accept) |=> (!job_valid_q || $stable(cur_s1)))
		else $error("job cursor changed mid job");

endmodule

### sim/lcdnw_checker.sv
// Scoreboard for the 4-bit character display writer: watches both channels,
// predicts the nibble writes of every accepted operation and compares them in order.
// Depends on lcdnw_pkg, lcdnw_op_if and lcdnw_nib_if.
`timescale 1ns / 1ps

module lcdnw_checker import lcdnw_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	lcdnw_op_if    req,
	lcdnw_nib_if   nib,
	output int     fail_count,
	output int     outstanding
);

	typedef struct packed {
		logic       rs;
		logic [3:0] nib;
		logic       last;
		logic [4:0] cursor;
	} nibble_write_t;

	logic [4:0]    cursor_track;
	logic [8:0]    byte_list[$];       // {rs, byte} in send order
	nibble_write_t nibble_writes_due[$];
	nibble_write_t want;
	nibble_write_t beat;

	initial begin
		fail_count  = 0;
		outstanding = 0;
	end

	function automatic void queue_byte(input logic rs, input logic [7:0] b);
		if (byte_list.size() < MAX_BYTES)
			byte_list.push_back({rs, b});
	endfunction

	// DDRAM address wraps at 8 bits; only real cells move the tracked cursor
	function automatic void goto_cell(input logic [7:0] r, input logic [7:0] c);
		logic [7:0] addr;
		addr = {r[1:0], 6'd0} + c;
		queue_byte(1'b0, addr | CMD_DDRAM);
		if (c <= 8'd15) begin
			if (r == 8'd0)
				cursor_track = c[4:0];
			else if (r == 8'd1)
				cursor_track = {1'b1, c[3:0]};
		end
	endfunction

	function automatic void step_right();
		if (cursor_track == 5'd15) begin
			cursor_track = 5'd16;
			goto_cell(8'd1, 8'd0);
		end else if (cursor_track == 5'd31) begin
			cursor_track = 5'd0;
			goto_cell(8'd0, 8'd0);
		end else begin
			cursor_track = cursor_track + 5'd1;
		end
	endfunction

	function automatic void step_left();
		if (cursor_track == 5'd16)
			goto_cell(8'd0, 8'd15);
		else if (cursor_track == 5'd0)
			goto_cell(8'd1, 8'd15);
		else
			cursor_track = cursor_track - 5'd1;
	endfunction

	function automatic void put_char(input logic [7:0] c);
		if (c >= CHAR_LO && c <= CHAR_HI) begin
			queue_byte(1'b1, c);
			step_right();
		end
	endfunction

	function automatic void back_step();
		queue_byte(1'b0, CMD_SHIFT_L);
		step_left();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_track = '0;
			nibble_writes_due.delete();
			outstanding = 0;
		end else begin
			if (req.valid && req.ready) begin
				byte_list.delete();
				case (op_t'(req.operation))
				OP_CMD:     queue_byte(1'b0, req.byte_value);
				OP_CHAR:    put_char(req.byte_value);
				OP_SET_CUR: goto_cell(req.row, req.column);
				OP_CLEAR: begin
					queue_byte(1'b0, CMD_CLEAR);
					cursor_track = '0;
				end
				OP_SHIFT_R: begin
					if (cursor_track != 5'd31) begin
						queue_byte(1'b0, CMD_SHIFT_R);
						step_right();
					end
				end
				OP_SHIFT_L: back_step();
				OP_DELETE: begin
					back_step();
					put_char(CHAR_SPACE);
					back_step();
				end
				default: begin
					queue_byte(1'b0, CMD_INIT0);
					queue_byte(1'b0, CMD_INIT1);
					queue_byte(1'b0, CMD_FUNC);
					queue_byte(1'b0, CMD_DISP);
					queue_byte(1'b0, CMD_ENTRY);
					queue_byte(1'b0, CMD_CLEAR);
					cursor_track = '0;
				end
				endcase
				// cursor field carries the position after the whole operation
				for (int k = 0; k < byte_list.size(); k++) begin
					for (int h = 0; h < 2; h++) begin
						beat.rs     = byte_list[k][8];
						beat.nib    = h ? byte_list[k][3:0] : byte_list[k][7:4];
						beat.last   = (k == byte_list.size() - 1) && (h == 1);
						beat.cursor = cursor_track;
						nibble_writes_due.push_back(beat);
					end
				end
			end
			if (nib.valid && nib.ready) begin
				if (nibble_writes_due.size() == 0) begin
					$error("unexpected nibble beat: rs %0d nibble %h last %0d cursor %0d",
						nib.register_select, nib.nibble, nib.last, nib.cursor);
					fail_count++;
				end else begin
					want = nibble_writes_due.pop_front();
					if (nib.register_select !== want.rs) begin
						$error("register_select: expected %0d, got %0d",
							want.rs, nib.register_select);
						fail_count++;
					end
					if (nib.nibble !== want.nib) begin
						$error("nibble: expected %h, got %h", want.nib, nib.nibble);
						fail_count++;
					end
					if (nib.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, nib.last);
						fail_count++;
					end
					if (nib.cursor !== want.cursor) begin
						$error("cursor: expected %0d, got %0d", want.cursor, nib.cursor);
						fail_count++;
					end
				end
			end
			outstanding = nibble_writes_due.size();
		end
	end

endmodule

### sim/tb.sv
// Top of the display writer bench: clock, reset, operation stimulus and ready stalls.
// Depends on lcdnw_pkg, both channel interfaces, the block and lcdnw_checker.
`timescale 1ns / 1ps

module tb import lcdnw_pkg::*;;

	logic clk;
	logic arst_n;
	logic calm;        // no idling on either side while set
	int   fail_count;
	int   outstanding;

	lcdnw_op_if  req_ch ();
	lcdnw_nib_if nib_ch ();

	char_lcd_nibble_writer_with_cursor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.nib    (nib_ch)
	);

	lcdnw_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.nib         (nib_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("Test completed with failures");
		$finish;
	end

	// sink side stalls
	initial begin
		nib_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			nib_ch.ready = calm || ($urandom_range(0, 99) >= 28);
		end
	end

	// called at a falling edge; returns at the falling edge after the beat
	task automatic issue_op(input op_t op, input logic [7:0] bv,
			input logic [7:0] r, input logic [7:0] c);
		if (!calm && $urandom_range(0, 99) < 28) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_ch.valid      = 1'b1;
		req_ch.operation  = op;
		req_ch.byte_value = bv;
		req_ch.row        = r;
		req_ch.column     = c;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
	endtask

	initial begin
		int         counted;
		int         pick;
		op_t        op;
		logic [7:0] bv;
		logic [7:0] r;
		logic [7:0] c;

		calm              = 1'b0;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.operation  = OP_CMD;
		req_ch.byte_value = '0;
		req_ch.row        = '0;
		req_ch.column     = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: byte extremes, printable bounds, row ends and wraps
		issue_op(OP_INIT,    8'h00, 8'd0,   8'd0);
		issue_op(OP_CMD,     8'h00, 8'd0,   8'd0);
		issue_op(OP_CMD,     8'hFF, 8'd0,   8'd0);
		issue_op(OP_CHAR,    8'd31, 8'd0,   8'd0);
		issue_op(OP_CHAR,    8'd32, 8'd0,   8'd0);
		issue_op(OP_CHAR,    8'd125, 8'd0,  8'd0);
		issue_op(OP_CHAR,    8'd126, 8'd0,  8'd0);
		issue_op(OP_CHAR,    8'hFF, 8'd0,   8'd0);
		issue_op(OP_SET_CUR, 8'h00, 8'd0,   8'd15);
		issue_op(OP_CHAR,    8'h41, 8'd0,   8'd0);
		issue_op(OP_SHIFT_L, 8'h00, 8'd0,   8'd0);
		issue_op(OP_SHIFT_R, 8'h00, 8'd0,   8'd0);
		issue_op(OP_DELETE,  8'h00, 8'd0,   8'd0);
		issue_op(OP_SET_CUR, 8'h00, 8'd1,   8'd15);
		issue_op(OP_SHIFT_R, 8'h00, 8'd0,   8'd0);
		issue_op(OP_CHAR,    8'h7A, 8'd0,   8'd0);
		issue_op(OP_SHIFT_L, 8'h00, 8'd0,   8'd0);
		issue_op(OP_CLEAR,   8'h00, 8'd0,   8'd0);
		issue_op(OP_DELETE,  8'h00, 8'd0,   8'd0);
		issue_op(OP_SET_CUR, 8'h00, 8'd255, 8'd255);
		issue_op(OP_SET_CUR, 8'h00, 8'd2,   8'd5);
		issue_op(OP_SET_CUR, 8'h00, 8'd1,   8'd16);
		issue_op(OP_SET_CUR, 8'h00, 8'd0,   8'd0);
		issue_op(OP_DELETE,  8'h00, 8'd0,   8'd0);
		issue_op(OP_INIT,    8'h00, 8'd0,   8'd0);

		// random: mostly text and cursor moves so the row ends get crossed often
		counted = 0;
		while (counted < 105) begin
			calm = (counted >= 40 && counted < 70);
			bv   = 8'($urandom_range(0, 255));
			r    = 8'($urandom_range(0, 255));
			c    = 8'($urandom_range(0, 255));
			pick = $urandom_range(0, 99);
			if (pick < 10)
				op = OP_CMD;
			else if (pick < 40) begin
				op = OP_CHAR;
				if ($urandom_range(0, 9) != 0)
					bv = 8'($urandom_range(32, 125));
			end else if (pick < 55) begin
				op = OP_SET_CUR;
				if ($urandom_range(0, 9) < 7) begin
					r = 8'($urandom_range(0, 1));
					c = 8'($urandom_range(0, 15));
				end
			end else if (pick < 60)
				op = OP_CLEAR;
			else if (pick < 72)
				op = OP_SHIFT_R;
			else if (pick < 84)
				op = OP_SHIFT_L;
			else if (pick < 95)
				op = OP_DELETE;
			else
				op = OP_INIT;
			issue_op(op, bv, r, c);
			if (!(op == OP_CHAR && (bv < CHAR_LO || bv > CHAR_HI)))
				counted++;
		end
		calm         = 1'b0;
		req_ch.valid = 1'b0;

		while (outstanding != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### sim.f
rtl/core/lcdnw_pkg.sv
rtl/core/lcdnw_op_if.sv
rtl/core/lcdnw_nib_if.sv
rtl/core/char_lcd_nibble_writer_with_cursor.sv
sim/lcdnw_checker.sv
sim/tb.sv
